@@ design/mvp_pkg.sv @@
// Shared types and constants for the matrix-vector product block.
// No dependencies.
package mvp_pkg;

  localparam int unsigned ACC_W     = 40;  // Q15.24 accumulator / dot product
  localparam int unsigned IDX_W     = 8;   // vector_index field
  localparam int unsigned ROW_NUM_W = 8;   // row_number field
  localparam int unsigned CFG_W     = 9;   // configuration data width
  localparam int unsigned CFG_IDX_W = 8;   // configuration index width
  localparam int unsigned OUT_TDATA_W = ((ACC_W + ROW_NUM_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_VECTOR = 1'b0,
    CMD_MATRIX = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 8'd0,
    CFG_ROWS    = 8'd1
  } cfg_idx_e;

  // Per-beat row bookkeeping carried down the pipe with each matrix element.
  typedef struct packed {
    logic                 row_end;
    logic                 final_row;
    logic [ROW_NUM_W-1:0] row_number;
  } row_tag_t;

endpackage

@@ design/matrix_vector_product.sv @@
// Top level of the matrix-vector product block: stream ports, config registers,
// column/row sequencing. Depends on mvp_pkg, mvp_vec_store and mvp_mac.
//
// Usage: write columns_in_use (index 0) and rows_in_use (index 1) on the cfg
//   channel while idle; cfg_ready_o is always high. Then send vector beats
//   (tuser = 0) carrying element_value and vector_index, followed by matrix
//   beats (tuser = 1) in row-major order. The element for column c is
//   multiplied by vector entry c and summed exactly into a 40-bit Q15.24 row
//   accumulator. After the last column of a row one result beat leaves on the
//   master side: dot product, row number, tlast set on the final row. Vector
//   beats and non-final columns produce no result.
// Result path: after the last matrix beat of a row is taken, the result passes
//   the store read at the accept edge, the multiply register and the output
//   register before it can leave.
// Throughput: one beat per cycle, vector or matrix, unless the output stalls;
//   the store has one write and one read port, so writes and reads never compete.
// Stall: while a result sits in the output register and m_axis_tready is low,
//   the whole pipe holds and s_axis_tready drops; otherwise input keeps flowing.
// Reset: counters and accumulator clear, both counts return to 256 (clamped to
//   the parameters). The vector store is not cleared; write every entry that a
//   row will read before streaming the matrix.
module matrix_vector_product
  import mvp_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: element_value [VALUE_WIDTH-1:0], vector_index [+7:VALUE_WIDTH], zero pad
  input  logic [((VALUE_WIDTH + IDX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: cmd (0 vector write, 1 matrix element)
  input  logic                     s_axis_tuser,
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata: dot_value [39:0], row_number [47:40]
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                     m_axis_tlast,   // final_row
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_COLUMNS);
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CCMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int unsigned RCMPW = ((RW > CFG_W) ? RW : CFG_W) + 1;

  // Config registers, held already clamped to 1..MAX.
  logic [CFG_W-1:0] cols_q, cols_d;
  logic [CFG_W-1:0] rows_q, rows_d;

  // Sequencer state.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Stage 1: element value and row tag aligned with the store read data.
  logic                          s1_valid_q, s1_valid_d;
  logic signed [VALUE_WIDTH-1:0] a_q;
  row_tag_t                      tag_q, tag_d;

  logic                          advance;
  logic                          in_fire;
  logic                          is_matrix;
  logic                          mat_fire;
  logic                          vec_fire;
  logic [VALUE_WIDTH-1:0]        in_value;
  logic [IDX_W-1:0]              in_index;
  logic                          idx_in_range;
  logic [VALUE_WIDTH-1:0]        vec_rdata;
  logic                          row_end;
  logic                          final_row;

  function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input int unsigned maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

  assign in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_index  = s_axis_tdata[VALUE_WIDTH +: IDX_W];
  assign is_matrix = (cmd_e'(s_axis_tuser) == CMD_MATRIX);

  assign s_axis_tready = advance;
  assign in_fire       = s_axis_tvalid && advance;
  assign mat_fire      = in_fire && is_matrix;
  assign vec_fire      = in_fire && !is_matrix;
  // Indexes beyond the store (possible only when it is shallower than 256) drop.
  assign idx_in_range  = (32'(in_index) < MAX_COLUMNS);

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COLUMNS: cols_d = clamp_count(cfg_data_i, MAX_COLUMNS);
        CFG_ROWS:    rows_d = clamp_count(cfg_data_i, MAX_ROWS);
        default:     ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Column / row sequencing, done at accept time; positions never wait on data.
  // ---------------------------------------------------------------------------
  assign row_end   = (CCMPW'(col_q) + CCMPW'(1)) >= CCMPW'(cols_q);
  assign final_row = (RCMPW'(row_q) + RCMPW'(1)) >= RCMPW'(rows_q);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_valid_d = advance ? mat_fire : s1_valid_q;

    tag_d.row_end    = row_end;
    tag_d.final_row  = final_row;
    tag_d.row_number = ROW_NUM_W'(row_q);

    if (mat_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = final_row ? '0 : RW'(RCMPW'(row_q) + RCMPW'(1));
      end else begin
        col_d = CW'(CCMPW'(col_q) + CCMPW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= clamp_count(CFG_W'(256), MAX_COLUMNS);
      rows_q     <= clamp_count(CFG_W'(256), MAX_ROWS);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cols_q     <= cols_d;
      rows_q     <= rows_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_fire) begin
      a_q   <= in_value;
      tag_q <= tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Vector store: written by vector beats, read at the current column by
  // matrix beats. A write always lands at an earlier edge than any later read.
  // ---------------------------------------------------------------------------
  mvp_vec_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (VALUE_WIDTH)
  ) u_vec_store (
    .clk_i   (clk_i),
    .we_i    (vec_fire && idx_in_range),
    .waddr_i (CW'(in_index)),
    .wdata_i (in_value),
    .re_i    (mat_fire),
    .raddr_i (col_q),
    .rdata_o (vec_rdata)
  );

  // ---------------------------------------------------------------------------
  // Multiply, accumulate and output register
  // ---------------------------------------------------------------------------
  mvp_mac #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid_q),
    .a_i           (a_q),
    .b_i           (signed'(vec_rdata)),
    .tag_i         (tag_q),
    .advance_o     (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ design/mvp_vec_store.sv @@
// Vector element store: one write port, one synchronous read port.
// Does not import mvp_pkg; no dependencies.
module mvp_vec_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mvp_mac.sv @@
// Multiply stage, row accumulator and output register of the product pipe.
// Depends on mvp_pkg (row_tag_t, widths).
module mvp_mac
  import mvp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  input  row_tag_t                      tag_i,
  output logic                          advance_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int unsigned PW = 2 * VALUE_WIDTH;

  logic                    s2_valid_q, s2_valid_d;
  logic signed [PW-1:0]    prod_q;
  row_tag_t                tag2_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] sum;
  logic                    out_valid_q, out_valid_d;
  logic [ACC_W-1:0]        dot_q;
  logic [ROW_NUM_W-1:0]    row_num_q;
  logic                    last_q;
  logic                    load_out;

  // Pipe moves unless a finished result is stuck in the output register.
  assign advance_o = !out_valid_q || m_axis_tready;

  assign sum      = acc_q + ACC_W'(prod_q);
  assign load_out = advance_o && s2_valid_q && tag2_q.row_end;

  always_comb begin
    s2_valid_d  = advance_o ? s1_valid_i : s2_valid_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (advance_o && s2_valid_q) begin
      acc_d = tag2_q.row_end ? '0 : sum;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && s1_valid_i) begin
      prod_q <= a_i * b_i;
      tag2_q <= tag_i;
    end
    if (load_out) begin
      dot_q     <= sum;
      row_num_q <= tag2_q.row_number;
      last_q    <= tag2_q.final_row;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({row_num_q, dot_q});
  assign m_axis_tlast  = last_q;

endmodule
